[rtl/ucrh_pkg.sv]
// shared types, constants and descriptor tables for the control request handler
package ucrh_pkg;

  typedef enum logic [2:0] {
    OP_SETUP  = 3'd0,
    OP_IN     = 3'd1,
    OP_OUT    = 3'd2,
    OP_BUSRST = 3'd3,
    OP_REPORT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ZLP    = 2'd1,
    KIND_STALL  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  localparam logic [7:0] REQ_GET_STATUS  = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEAT  = 8'd1;
  localparam logic [7:0] REQ_SET_FEAT    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESC    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

  localparam logic [7:0] RT_EP_IN   = 8'h82;
  localparam logic [7:0] RT_DEV_IN  = 8'h80;
  localparam logic [7:0] RT_EP_OUT  = 8'h02;
  localparam logic [7:0] RT_DEV_OUT = 8'h00;

  localparam logic [2:0] EP_CTRL   = 3'd0;
  localparam logic [2:0] EP_REPORT = 3'd3;

  localparam int TABLE_ENTRIES = 7;
  localparam int ROM_IMAGE     = 129;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEND_DESC,
    ST_SEND_REPORT,
    ST_SEND_ONE
  } state_e;

  typedef struct packed {
    logic step_report;
    logic search_start;
    logic search_step;
    logic desc_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic search_hit;
    logic search_done;
    logic desc_done;
    logic report_done;
    logic desc_ready;
  } stat_t;

  function automatic logic [7:0] rom_byte(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'd0: r = 8'd18; 8'd1: r = 8'd1; 8'd2: r = 8'h00; 8'd3: r = 8'h02;
      8'd4: r = 8'd0; 8'd5: r = 8'd0; 8'd6: r = 8'd0; 8'd7: r = 8'd32;
      8'd8: r = 8'hC0; 8'd9: r = 8'h16; 8'd10: r = 8'h79; 8'd11: r = 8'h04;
      8'd12: r = 8'h00; 8'd13: r = 8'h01; 8'd14: r = 8'd1; 8'd15: r = 8'd2;
      8'd16: r = 8'd0; 8'd17: r = 8'd1;
      8'd18: r = 8'd9; 8'd19: r = 8'd2; 8'd20: r = 8'd34; 8'd21: r = 8'd0;
      8'd22: r = 8'd1; 8'd23: r = 8'd1; 8'd24: r = 8'd0; 8'd25: r = 8'hC0;
      8'd26: r = 8'd50;
      8'd27: r = 8'd9; 8'd28: r = 8'd4; 8'd29: r = 8'd0; 8'd30: r = 8'd0;
      8'd31: r = 8'd1; 8'd32: r = 8'h03; 8'd33: r = 8'h00; 8'd34: r = 8'h00;
      8'd35: r = 8'd0;
      8'd36: r = 8'd9; 8'd37: r = 8'h21; 8'd38: r = 8'h11; 8'd39: r = 8'h01;
      8'd40: r = 8'd0; 8'd41: r = 8'd1; 8'd42: r = 8'h22; 8'd43: r = 8'd21;
      8'd44: r = 8'd0;
      8'd45: r = 8'd7; 8'd46: r = 8'd5; 8'd47: r = 8'h83; 8'd48: r = 8'h03;
      8'd49: r = 8'd32; 8'd50: r = 8'd0; 8'd51: r = 8'd1;
      8'd52: r = 8'h06; 8'd53: r = 8'h31; 8'd54: r = 8'hFF; 8'd55: r = 8'h09;
      8'd56: r = 8'h74; 8'd57: r = 8'hA1; 8'd58: r = 8'h53; 8'd59: r = 8'h75;
      8'd60: r = 8'h08; 8'd61: r = 8'h15; 8'd62: r = 8'h00; 8'd63: r = 8'h26;
      8'd64: r = 8'hFF; 8'd65: r = 8'h00; 8'd66: r = 8'h95; 8'd67: r = 8'd9;
      8'd68: r = 8'h09; 8'd69: r = 8'h75; 8'd70: r = 8'h81; 8'd71: r = 8'h02;
      8'd72: r = 8'hC0;
      8'd73: r = 8'd4; 8'd74: r = 8'd3; 8'd75: r = 8'h09; 8'd76: r = 8'h04;
      8'd77: r = 8'd20; 8'd78: r = 8'd3;
      8'd79: r = 8'h59; 8'd81: r = 8'h6F; 8'd83: r = 8'h75; 8'd85: r = 8'h72;
      8'd87: r = 8'h20; 8'd89: r = 8'h4E; 8'd91: r = 8'h61; 8'd93: r = 8'h6D;
      8'd95: r = 8'h65;
      8'd97: r = 8'd32; 8'd98: r = 8'd3;
      8'd99: r = 8'h59; 8'd101: r = 8'h6F; 8'd103: r = 8'h75; 8'd105: r = 8'h72;
      8'd107: r = 8'h20; 8'd109: r = 8'h55; 8'd111: r = 8'h53; 8'd113: r = 8'h42;
      8'd115: r = 8'h20; 8'd117: r = 8'h44; 8'd119: r = 8'h65; 8'd121: r = 8'h76;
      8'd123: r = 8'h69; 8'd125: r = 8'h63; 8'd127: r = 8'h65;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [15:0] val;
    logic [15:0] idx;
    logic [7:0]  start;
    logic [7:0]  len;
  } desc_entry_t;

  function automatic desc_entry_t desc_entry(input logic [3:0] i);
    desc_entry_t e;
    case (i)
      4'd0: e = '{16'h0100, 16'h0000, 8'd0, 8'd18};
      4'd1: e = '{16'h0200, 16'h0000, 8'd18, 8'd34};
      4'd2: e = '{16'h2200, 16'h0000, 8'd52, 8'd21};
      4'd3: e = '{16'h2100, 16'h0000, 8'd36, 8'd9};
      4'd4: e = '{16'h0300, 16'h0000, 8'd73, 8'd4};
      4'd5: e = '{16'h0301, 16'h0409, 8'd77, 8'd20};
      4'd6: e = '{16'h0302, 16'h0409, 8'd97, 8'd32};
      default: e = '{16'h0000, 16'h0000, 8'd0, 8'd0};
    endcase
    return e;
  endfunction

endpackage

[rtl/ucrh_datapath.sv]
// datapath: request decode, descriptor walk, report shifter, device state
module ucrh_datapath #(
  parameter int MAX_EP_NUMBER = 4,
  parameter int PACKET_BYTES  = 32,
  parameter int DESC_ENTRIES  = 7,
  parameter int ROM_BYTES     = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        op_i,
  input  logic [7:0]        request_type_i,
  input  logic [7:0]        request_i,
  input  logic [15:0]       value_i,
  input  logic [15:0]       index_i,
  input  logic [15:0]       length_i,
  input  logic [7:0]        report_type_i,
  input  logic [15:0]       delta_time_i,
  input  logic [15:0]       x_value_i,
  input  logic [15:0]       y_value_i,
  input  logic [15:0]       z_value_i,
  input  ucrh_pkg::cmd_t    cmd_i,
  output ucrh_pkg::stat_t   stat_o,
  output logic              one_valid_o,
  output logic [1:0]        kind_o,
  output logic [2:0]        endpoint_o,
  output logic [7:0]        data_byte_o,
  output logic              end_of_packet_o,
  output logic              last_o,
  output logic [6:0]        device_address_o,
  output logic              address_enabled_o,
  output logic [7:0]        configuration_o
);

  localparam int Chunk = (PACKET_BYTES < 32) ? PACKET_BYTES : 32;
  localparam int Entries = (DESC_ENTRIES < ucrh_pkg::TABLE_ENTRIES) ?
                           DESC_ENTRIES : ucrh_pkg::TABLE_ENTRIES;

  logic [7:0]  cfg_q;
  logic [6:0]  addr_q;
  logic        addr_ok_q;
  logic        active_q;
  logic [7:0]  cursor_q;
  logic [7:0]  left_q;
  logic [7:0]  halted_q;
  logic [71:0] rep_q;
  logic [3:0]  rep_cnt_q;
  logic [3:0]  srch_q;
  logic [15:0] val_q, idx_q, len_q;
  logic [5:0]  pkt_n_q;
  logic [5:0]  pkt_k_q;

  ucrh_pkg::desc_entry_t ent;
  logic hit;
  logic [7:0] clip;
  logic [7:0] n_now;
  logic [7:0] rom_q;
  logic [2:0] ep7;
  logic       ep_ok;

  assign ent = ucrh_pkg::desc_entry(srch_q);
  assign hit = (ent.val == val_q) && (ent.idx == idx_q);
  assign clip = (len_q < 16'd255) ? len_q[7:0] : 8'd255;
  assign n_now = (left_q < 8'(Chunk)) ? left_q : 8'(Chunk);
  assign ep7 = index_i[2:0];
  assign ep_ok = (index_i[6:0] >= 7'd1) && (index_i[6:0] <= 7'(MAX_EP_NUMBER))
                 && (index_i[6:0] < 7'd8);

  always_comb begin
    rom_q = 8'd0;
    if ((32'(cursor_q) < ucrh_pkg::ROM_IMAGE) && (32'(cursor_q) < ROM_BYTES)) begin
      rom_q = ucrh_pkg::rom_byte(cursor_q);
    end
  end

  assign stat_o.search_hit  = hit && (32'(srch_q) < Entries);
  assign stat_o.search_done = (32'(srch_q) >= Entries - 1);
  assign stat_o.desc_done   = (pkt_k_q + 6'd1 >= pkt_n_q);
  assign stat_o.report_done = (rep_cnt_q == 4'd8);
  assign stat_o.desc_ready  = active_q && (left_q != 8'd0);

  // immediate single/double result decode
  logic       dbl;
  logic [1:0] one_kind;
  logic [2:0] one_endpoint;
  logic [7:0] one_byte;
  logic       one_eop;
  logic       one_last;
  always_comb begin
    one_valid_o  = 1'b0;
    one_kind     = ucrh_pkg::KIND_STALL;
    one_endpoint = ucrh_pkg::EP_CTRL;
    one_byte     = 8'd0;
    one_eop      = 1'b0;
    one_last     = 1'b1;
    dbl          = 1'b0;
    case (op_i)
      ucrh_pkg::OP_SETUP: begin
        one_valid_o = (request_i != ucrh_pkg::REQ_GET_DESC);
        if (request_i == ucrh_pkg::REQ_SET_ADDRESS) begin
          one_kind = ucrh_pkg::KIND_ZLP;
          one_eop  = 1'b1;
        end else if (request_i == ucrh_pkg::REQ_SET_CONFIG &&
                     request_type_i == ucrh_pkg::RT_DEV_OUT) begin
          one_kind = ucrh_pkg::KIND_ZLP;
          one_eop  = 1'b1;
        end else if (request_i == ucrh_pkg::REQ_GET_CONFIG &&
                     request_type_i == ucrh_pkg::RT_DEV_IN) begin
          one_kind = ucrh_pkg::KIND_DATA;
          one_byte = cfg_q;
          one_eop  = 1'b1;
        end else if (request_i == ucrh_pkg::REQ_GET_STATUS) begin
          one_kind = ucrh_pkg::KIND_DATA;
          one_byte = {7'd0, (request_type_i == ucrh_pkg::RT_EP_IN) && halted_q[ep7]};
          one_last = 1'b0;
          dbl      = 1'b1;
        end else if ((request_i == ucrh_pkg::REQ_CLEAR_FEAT ||
                      request_i == ucrh_pkg::REQ_SET_FEAT) &&
                     request_type_i == ucrh_pkg::RT_EP_OUT &&
                     value_i == 16'd0 && ep_ok) begin
          one_kind = ucrh_pkg::KIND_ZLP;
          one_eop  = 1'b1;
        end
      end
      ucrh_pkg::OP_REPORT: begin
        one_valid_o  = (cfg_q == 8'd0);
        one_kind     = ucrh_pkg::KIND_REJECT;
        one_endpoint = ucrh_pkg::EP_REPORT;
      end
      ucrh_pkg::OP_IN: begin
        one_valid_o = active_q && (left_q == 8'd0);
        one_kind    = ucrh_pkg::KIND_ZLP;
        one_eop     = 1'b1;
      end
      default: one_valid_o = 1'b0;
    endcase
  end

  logic       out_v_q, out_eop_q, out_last_q;
  logic [1:0] out_kind_q;
  logic [2:0] out_ep_q;
  logic [7:0] out_byte_q;
  logic       pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= 8'd0;
      addr_q    <= 7'd0;
      addr_ok_q <= 1'b0;
      active_q  <= 1'b0;
      cursor_q  <= 8'd0;
      left_q    <= 8'd0;
      halted_q  <= 8'd0;
      rep_cnt_q <= 4'd0;
      srch_q    <= 4'd0;
      pkt_n_q   <= 6'd0;
      pkt_k_q   <= 6'd0;
      out_v_q   <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
      if (pend_q) begin
        out_v_q    <= 1'b1;
        out_kind_q <= ucrh_pkg::KIND_DATA;
        out_ep_q   <= ucrh_pkg::EP_CTRL;
        out_byte_q <= 8'd0;
        out_eop_q  <= 1'b1;
        out_last_q <= 1'b1;
      end
      if (accept_i) begin
        if (one_valid_o) begin
          out_v_q    <= 1'b1;
          out_kind_q <= one_kind;
          out_ep_q   <= one_endpoint;
          out_byte_q <= one_byte;
          out_eop_q  <= one_eop;
          out_last_q <= one_last;
        end
        pend_q <= dbl;
        case (op_i)
          ucrh_pkg::OP_SETUP: begin
            active_q <= 1'b0;
            val_q <= value_i;
            idx_q <= index_i;
            len_q <= length_i;
            if (request_i == ucrh_pkg::REQ_SET_ADDRESS) begin
              addr_q    <= value_i[6:0];
              addr_ok_q <= 1'b1;
            end else if (request_i == ucrh_pkg::REQ_SET_CONFIG &&
                         request_type_i == ucrh_pkg::RT_DEV_OUT) begin
              cfg_q <= value_i[7:0];
            end else if ((request_i == ucrh_pkg::REQ_CLEAR_FEAT ||
                          request_i == ucrh_pkg::REQ_SET_FEAT) &&
                         request_type_i == ucrh_pkg::RT_EP_OUT &&
                         value_i == 16'd0 && ep_ok) begin
              halted_q[index_i[2:0]] <= (request_i == ucrh_pkg::REQ_SET_FEAT);
            end
          end
          ucrh_pkg::OP_IN: begin
            if (active_q) begin
              pkt_n_q  <= n_now[5:0];
              pkt_k_q  <= 6'd0;
              left_q   <= left_q - n_now;
              active_q <= ((left_q - n_now) != 8'd0) || (n_now == 8'(Chunk));
            end
          end
          ucrh_pkg::OP_OUT: active_q <= 1'b0;
          ucrh_pkg::OP_BUSRST: begin
            active_q <= 1'b0;
            cfg_q    <= 8'd0;
          end
          ucrh_pkg::OP_REPORT: begin
            rep_q <= {report_type_i, delta_time_i, x_value_i, y_value_i, z_value_i};
            rep_cnt_q <= 4'd0;
          end
          default: ;
        endcase
      end
      if (cmd_i.search_start) srch_q <= 4'd0;
      if (cmd_i.search_step) begin
        if (stat_o.search_hit) begin
          cursor_q <= ent.start;
          left_q   <= (clip > ent.len) ? ent.len : clip;
          active_q <= 1'b1;
        end else begin
          srch_q <= srch_q + 4'd1;
        end
        if (cmd_i.emit) begin
          out_v_q    <= 1'b1;
          out_kind_q <= ucrh_pkg::KIND_STALL;
          out_ep_q   <= ucrh_pkg::EP_CTRL;
          out_byte_q <= 8'd0;
          out_eop_q  <= 1'b0;
          out_last_q <= 1'b1;
        end
      end
      if (cmd_i.desc_step) begin
        out_v_q    <= 1'b1;
        out_kind_q <= ucrh_pkg::KIND_DATA;
        out_ep_q   <= ucrh_pkg::EP_CTRL;
        out_byte_q <= rom_q;
        out_eop_q  <= stat_o.desc_done;
        out_last_q <= stat_o.desc_done;
        cursor_q   <= cursor_q + 8'd1;
        pkt_k_q    <= pkt_k_q + 6'd1;
      end
      if (cmd_i.step_report) begin
        out_v_q    <= 1'b1;
        out_kind_q <= ucrh_pkg::KIND_DATA;
        out_ep_q   <= ucrh_pkg::EP_REPORT;
        out_byte_q <= rep_q[71:64];
        out_eop_q  <= stat_o.report_done;
        out_last_q <= stat_o.report_done;
        rep_q      <= {rep_q[63:0], 8'd0};
        rep_cnt_q  <= rep_cnt_q + 4'd1;
      end
    end
  end

  assign kind_o            = out_v_q ? out_kind_q : ucrh_pkg::KIND_DATA;
  assign endpoint_o        = out_v_q ? out_ep_q : 3'd0;
  assign data_byte_o       = out_v_q ? out_byte_q : 8'd0;
  assign end_of_packet_o   = out_v_q & out_eop_q;
  assign last_o            = out_v_q & out_last_q;
  assign device_address_o  = addr_q;
  assign address_enabled_o = addr_ok_q;
  assign configuration_o   = cfg_q;

endmodule

[rtl/ucrh_ctrl.sv]
// controller state machine sequencing setup search and byte streams
module ucrh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [2:0]       op_i,
  input  logic [7:0]       request_i,
  input  logic             report_go_i,
  input  logic             pend_i,
  input  ucrh_pkg::stat_t  stat_i,
  output ucrh_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  ucrh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucrh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ucrh_pkg::ST_IDLE: begin
        busy_o = pend_i;
        if (accept_i) begin
          if (op_i == ucrh_pkg::OP_SETUP && request_i == ucrh_pkg::REQ_GET_DESC) begin
            cmd_o.search_start = 1'b1;
            state_d = ucrh_pkg::ST_SEARCH;
          end else if (op_i == ucrh_pkg::OP_IN && stat_i.desc_ready) begin
            state_d = ucrh_pkg::ST_SEND_DESC;
          end else if (op_i == ucrh_pkg::OP_REPORT && report_go_i) begin
            state_d = ucrh_pkg::ST_SEND_REPORT;
          end
        end
      end
      ucrh_pkg::ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.search_hit) begin
          state_d = ucrh_pkg::ST_IDLE;
        end else if (stat_i.search_done) begin
          cmd_o.emit = 1'b1;
          state_d = ucrh_pkg::ST_IDLE;
        end
      end
      ucrh_pkg::ST_SEND_DESC: begin
        cmd_o.desc_step = 1'b1;
        if (stat_i.desc_done) state_d = ucrh_pkg::ST_IDLE;
      end
      ucrh_pkg::ST_SEND_REPORT: begin
        cmd_o.step_report = 1'b1;
        if (stat_i.report_done) state_d = ucrh_pkg::ST_IDLE;
      end
      default: state_d = ucrh_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/usb_control_request_handler.sv]
// top level of the endpoint zero control request handler
// immediate results show in the cycle after start; IN packet and report bytes pass the
// state and output registers; get descriptor searches one entry per cycle and emits
// a stall on a miss; busy stays high while a 32-byte IN packet or 9-byte report is sent
// results cannot be stalled by the receiver
// reset clears address, configuration, halts and any data stage
module usb_control_request_handler #(
  parameter int MAX_EP_NUMBER = 4,
  parameter int PACKET_BYTES  = 32,
  parameter int DESC_ENTRIES  = 7,
  parameter int ROM_BYTES     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_i,
  input  logic [15:0] value_i,
  input  logic [15:0] index_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  report_type_i,
  input  logic [15:0] delta_time_i,
  input  logic [15:0] x_value_i,
  input  logic [15:0] y_value_i,
  input  logic [15:0] z_value_i,
  output logic        strobe,
  output logic [1:0]  kind_o,
  output logic [2:0]  endpoint_o,
  output logic [7:0]  data_byte_o,
  output logic        end_of_packet_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        address_enabled_o,
  output logic [7:0]  configuration_o
);

  ucrh_pkg::cmd_t  cmd;
  ucrh_pkg::stat_t stat;
  logic accept;
  logic one_valid;
  logic pend_q, strobe_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      pend_q   <= accept && op_i == ucrh_pkg::OP_SETUP &&
                  request_i == ucrh_pkg::REQ_GET_STATUS;
      strobe_q <= (accept && one_valid) || pend_q || cmd.desc_step ||
                  cmd.step_report || (cmd.search_step && cmd.emit);
    end
  end
  assign strobe = strobe_q;

  ucrh_datapath #(
    .MAX_EP_NUMBER(MAX_EP_NUMBER),
    .PACKET_BYTES (PACKET_BYTES),
    .DESC_ENTRIES (DESC_ENTRIES),
    .ROM_BYTES    (ROM_BYTES)
  ) u_dp (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .op_i, .request_type_i, .request_i, .value_i, .index_i, .length_i,
    .report_type_i, .delta_time_i, .x_value_i, .y_value_i, .z_value_i,
    .cmd_i(cmd), .stat_o(stat),
    .one_valid_o(one_valid),
    .kind_o, .endpoint_o, .data_byte_o, .end_of_packet_o, .last_o,
    .device_address_o, .address_enabled_o, .configuration_o
  );

  ucrh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .op_i, .request_i,
    .report_go_i(configuration_o != 8'd0),
    .pend_i(pend_q),
    .stat_i(stat),
    .cmd_o(cmd),
    .busy_o(busy)
  );

endmodule

[rtl/ucrh_checker.sv]
// port-level checker for the control request handler
module ucrh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [1:0] kind_o,
  input logic       end_of_packet_o,
  input logic       last_o,
  input logic [7:0] data_byte_o
);

  a_stall_no_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && kind_o == ucrh_pkg::KIND_STALL |-> !end_of_packet_o && last_o)
    else $error("stall with end of packet");

  a_zlp_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && kind_o == ucrh_pkg::KIND_ZLP |-> end_of_packet_o && data_byte_o == 8'd0)
    else $error("zero-length packet malformed");

  a_last_no_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_o |=> !strobe || $past(start && !busy))
    else $error("result after last");

endmodule

bind usb_control_request_handler ucrh_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .strobe, .kind_o, .end_of_packet_o, .last_o,
  .data_byte_o
);

[tb/usb_control_request_handler_test.sv]
// self-checking testbench for the endpoint zero control request handler
`timescale 1ns / 1ps

module usb_control_request_handler_test;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  rtype;
    logic [7:0]  req;
    logic [15:0] val;
    logic [15:0] idx;
    logic [15:0] len;
    logic [7:0]  rep_type;
    logic [15:0] dt;
    logic [15:0] xv;
    logic [15:0] yv;
    logic [15:0] zv;
    int          idle_pct;
  } event_t;

  typedef struct {
    logic [1:0] kind;
    logic [2:0] ep;
    logic [7:0] data;
    logic       eop;
    logic       last;
    logic [6:0] addr;
    logic       addr_en;
    logic [7:0] cfg;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  op_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_i = '0;
  logic [15:0] value_i = '0;
  logic [15:0] index_i = '0;
  logic [15:0] length_i = '0;
  logic [7:0]  report_type_i = '0;
  logic [15:0] delta_time_i = '0;
  logic [15:0] x_value_i = '0;
  logic [15:0] y_value_i = '0;
  logic [15:0] z_value_i = '0;
  logic        strobe;
  logic [1:0]  kind_o;
  logic [2:0]  endpoint_o;
  logic [7:0]  data_byte_o;
  logic        end_of_packet_o;
  logic        last_o;
  logic [6:0]  device_address_o;
  logic        address_enabled_o;
  logic [7:0]  configuration_o;

  usb_control_request_handler u_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .request_type_i, .request_i, .value_i,
    .index_i, .length_i, .report_type_i, .delta_time_i, .x_value_i, .y_value_i,
    .z_value_i, .strobe, .kind_o, .endpoint_o, .data_byte_o, .end_of_packet_o,
    .last_o, .device_address_o, .address_enabled_o, .configuration_o
  );

  always #1 clk_i = ~clk_i;

  logic [7:0] desc_bytes [0:128] = '{
    18, 1, 8'h00, 8'h02, 0, 0, 0, 32, 8'hC0, 8'h16, 8'h79, 8'h04, 8'h00, 8'h01, 1, 2, 0, 1,
    9, 2, 34, 0, 1, 1, 0, 8'hC0, 50,
    9, 4, 0, 0, 1, 8'h03, 8'h00, 8'h00, 0,
    9, 8'h21, 8'h11, 8'h01, 0, 1, 8'h22, 21, 0,
    7, 5, 8'h83, 8'h03, 32, 0, 1,
    8'h06, 8'h31, 8'hFF, 8'h09, 8'h74, 8'hA1, 8'h53, 8'h75, 8'h08, 8'h15, 8'h00,
    8'h26, 8'hFF, 8'h00, 8'h95, 9, 8'h09, 8'h75, 8'h81, 8'h02, 8'hC0,
    4, 3, 8'h09, 8'h04,
    20, 3, 8'h59, 0, 8'h6F, 0, 8'h75, 0, 8'h72, 0, 8'h20, 0, 8'h4E, 0, 8'h61, 0,
    8'h6D, 0, 8'h65, 0,
    32, 3, 8'h59, 0, 8'h6F, 0, 8'h75, 0, 8'h72, 0, 8'h20, 0, 8'h55, 0, 8'h53, 0,
    8'h42, 0, 8'h20, 0, 8'h44, 0, 8'h65, 0, 8'h76, 0, 8'h69, 0, 8'h63, 0, 8'h65, 0
  };
  logic [15:0] dsc_val [0:6] = '{16'h0100, 16'h0200, 16'h2200, 16'h2100, 16'h0300,
                                 16'h0301, 16'h0302};
  logic [15:0] dsc_idx [0:6] = '{0, 0, 0, 0, 0, 16'h0409, 16'h0409};
  logic [7:0]  dsc_start [0:6] = '{0, 18, 52, 36, 73, 77, 97};
  logic [7:0]  dsc_len [0:6] = '{18, 34, 21, 9, 4, 20, 32};

  logic [7:0] cfg_q;
  logic [6:0] addr_q;
  logic       addr_en_q;
  logic       stage_q;
  logic [7:0] cursor_q;
  logic [7:0] left_q;
  logic       halted_q [0:7];

  event_t  pending_words [$];
  result_t expected_words [$];
  result_t new_words [$];
  event_t  cur;
  int      accepted = 0;
  int      results_seen = 0;
  int      errors = 0;
  int      cycles = 0;
  int      phase_idle = 0;

  function automatic void add_word(logic [1:0] k, logic [2:0] e, logic [7:0] d, logic eop);
    result_t r;
    r.kind = k; r.ep = e; r.data = d; r.eop = eop; r.last = 1'b0;
    r.addr = '0; r.addr_en = 1'b0; r.cfg = '0;
    new_words.push_back(r);
  endfunction

  task automatic predict_event(input event_t ev);
    int n;
    bit hit;
    logic [15:0] lim;
    logic [7:0] b;
    logic [2:0] hep;
    new_words.delete();
    case (ev.op)
      ucrh_pkg::OP_SETUP: begin
        stage_q = 1'b0;
        if (ev.req == ucrh_pkg::REQ_SET_ADDRESS) begin
          add_word(ucrh_pkg::KIND_ZLP, ucrh_pkg::EP_CTRL, 8'd0, 1'b1);
          addr_q = ev.val[6:0];
          addr_en_q = 1'b1;
        end else if (ev.req == ucrh_pkg::REQ_GET_DESC) begin
          hit = 0;
          for (int i = 0; i < 7; i++) begin
            if (!hit && dsc_val[i] == ev.val && dsc_idx[i] == ev.idx) begin
              hit = 1;
              lim = (ev.len < 16'd255) ? ev.len : 16'd255;
              if (lim > {8'd0, dsc_len[i]}) lim = {8'd0, dsc_len[i]};
              cursor_q = dsc_start[i];
              left_q = lim[7:0];
              stage_q = 1'b1;
            end
          end
          if (!hit) add_word(ucrh_pkg::KIND_STALL, ucrh_pkg::EP_CTRL, 8'd0, 1'b0);
        end else if (ev.req == ucrh_pkg::REQ_SET_CONFIG &&
                     ev.rtype == ucrh_pkg::RT_DEV_OUT) begin
          cfg_q = ev.val[7:0];
          add_word(ucrh_pkg::KIND_ZLP, ucrh_pkg::EP_CTRL, 8'd0, 1'b1);
        end else if (ev.req == ucrh_pkg::REQ_GET_CONFIG &&
                     ev.rtype == ucrh_pkg::RT_DEV_IN) begin
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_CTRL, cfg_q, 1'b1);
        end else if (ev.req == ucrh_pkg::REQ_GET_STATUS) begin
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_CTRL,
                   (ev.rtype == ucrh_pkg::RT_EP_IN && halted_q[ev.idx[2:0]]) ? 8'd1 : 8'd0,
                   1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_CTRL, 8'd0, 1'b1);
        end else if ((ev.req == ucrh_pkg::REQ_CLEAR_FEAT || ev.req == ucrh_pkg::REQ_SET_FEAT) &&
                     ev.rtype == ucrh_pkg::RT_EP_OUT && ev.val == 16'd0 &&
                     ev.idx[6:0] >= 7'd1 && ev.idx[6:0] <= 7'd4) begin
          add_word(ucrh_pkg::KIND_ZLP, ucrh_pkg::EP_CTRL, 8'd0, 1'b1);
          hep = ev.idx[2:0];
          halted_q[hep] = (ev.req == ucrh_pkg::REQ_SET_FEAT);
        end else begin
          add_word(ucrh_pkg::KIND_STALL, ucrh_pkg::EP_CTRL, 8'd0, 1'b0);
        end
      end
      ucrh_pkg::OP_IN: begin
        if (stage_q) begin
          n = (left_q < 8'd32) ? int'(left_q) : 32;
          if (n == 0) add_word(ucrh_pkg::KIND_ZLP, ucrh_pkg::EP_CTRL, 8'd0, 1'b1);
          for (int k = 0; k < n; k++) begin
            b = (cursor_q < 8'd129) ? desc_bytes[cursor_q] : 8'd0;
            add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_CTRL, b, k + 1 == n);
            cursor_q = cursor_q + 8'd1;
          end
          left_q = left_q - n[7:0];
          stage_q = (left_q != 8'd0) || (n == 32);
        end
      end
      ucrh_pkg::OP_OUT: stage_q = 1'b0;
      ucrh_pkg::OP_BUSRST: begin
        cfg_q = '0;
        stage_q = 1'b0;
      end
      ucrh_pkg::OP_REPORT: begin
        if (cfg_q == 8'd0) begin
          add_word(ucrh_pkg::KIND_REJECT, ucrh_pkg::EP_REPORT, 8'd0, 1'b0);
        end else begin
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.rep_type, 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.dt[15:8], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.dt[7:0], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.xv[15:8], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.xv[7:0], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.yv[15:8], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.yv[7:0], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.zv[15:8], 1'b0);
          add_word(ucrh_pkg::KIND_DATA, ucrh_pkg::EP_REPORT, ev.zv[7:0], 1'b1);
        end
      end
      default: ;
    endcase
    for (int k = 0; k < new_words.size(); k++) begin
      new_words[k].last = (k + 1 == new_words.size());
      new_words[k].addr = addr_q;
      new_words[k].addr_en = addr_en_q;
      new_words[k].cfg = cfg_q;
      expected_words.push_back(new_words[k]);
    end
  endtask

  function automatic event_t blank_event(logic [2:0] op);
    event_t ev;
    ev.op = op; ev.rtype = '0; ev.req = '0; ev.val = '0; ev.idx = '0; ev.len = '0;
    ev.rep_type = '0; ev.dt = '0; ev.xv = '0; ev.yv = '0; ev.zv = '0; ev.idle_pct = 0;
    return ev;
  endfunction

  task automatic push_setup(logic [7:0] rt, logic [7:0] rq, logic [15:0] v,
                            logic [15:0] ix, logic [15:0] ln);
    event_t ev;
    ev = blank_event(ucrh_pkg::OP_SETUP);
    ev.rtype = rt; ev.req = rq; ev.val = v; ev.idx = ix; ev.len = ln;
    ev.idle_pct = phase_idle;
    pending_words.push_back(ev);
  endtask

  task automatic push_op(logic [2:0] op);
    event_t ev;
    ev = blank_event(op);
    ev.idle_pct = phase_idle;
    pending_words.push_back(ev);
  endtask

  task automatic push_report(logic [7:0] t, logic [15:0] d, logic [15:0] x,
                             logic [15:0] y, logic [15:0] z);
    event_t ev;
    ev = blank_event(ucrh_pkg::OP_REPORT);
    ev.rep_type = t; ev.dt = d; ev.xv = x; ev.yv = y; ev.zv = z;
    ev.idle_pct = phase_idle;
    pending_words.push_back(ev);
  endtask

  // driver: a word is taken when start is high and busy low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_event(cur);
        accepted++;
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 &&
            $urandom_range(99) >= pending_words[0].idle_pct) begin
          cur = pending_words.pop_front();
          start <= 1'b1;
          op_i <= cur.op;
          request_type_i <= cur.rtype;
          request_i <= cur.req;
          value_i <= cur.val;
          index_i <= cur.idx;
          length_i <= cur.len;
          report_type_i <= cur.rep_type;
          delta_time_i <= cur.dt;
          x_value_i <= cur.xv;
          y_value_i <= cur.yv;
          z_value_i <= cur.zv;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t w;
    cycles++;
    if (rst_ni && strobe) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d ep=%0d data=%h", $time,
                 kind_o, endpoint_o, data_byte_o);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if ({kind_o, endpoint_o, data_byte_o, end_of_packet_o, last_o, device_address_o,
             address_enabled_o, configuration_o} !==
            {w.kind, w.ep, w.data, w.eop, w.last, w.addr, w.addr_en, w.cfg}) begin
          $display("%0t: expected kind=%0d ep=%0d data=%h eop=%b last=%b addr=%h aen=%b cfg=%h",
                   $time, w.kind, w.ep, w.data, w.eop, w.last, w.addr, w.addr_en, w.cfg);
          $display("%0t: actual   kind=%0d ep=%0d data=%h eop=%b last=%b addr=%h aen=%b cfg=%h",
                   $time, kind_o, endpoint_o, data_byte_o, end_of_packet_o, last_o,
                   device_address_o, address_enabled_o, configuration_o);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_random_sequence();
    int sel;
    int e;
    event_t ev;
    sel = $urandom_range(99);
    if (sel < 35) begin
      e = $urandom_range(6);
      push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_DESC, dsc_val[e], dsc_idx[e],
                 16'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(40)));
      repeat ($urandom_range(1, 3)) push_op(ucrh_pkg::OP_IN);
      if ($urandom_range(5) == 0) push_op(ucrh_pkg::OP_OUT);
      if ($urandom_range(3) == 0) push_op(ucrh_pkg::OP_IN);
    end else if (sel < 42) begin
      push_setup(8'($urandom()), ucrh_pkg::REQ_SET_ADDRESS, 16'($urandom()),
                 16'($urandom()), 16'($urandom()));
    end else if (sel < 50) begin
      push_setup(ucrh_pkg::RT_DEV_OUT, ucrh_pkg::REQ_SET_CONFIG,
                 16'(($urandom_range(3) == 0) ? 0 : $urandom()),
                 16'($urandom()), 16'($urandom()));
    end else if (sel < 55) begin
      push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_CONFIG, 16'($urandom()),
                 16'($urandom()), 16'($urandom()));
    end else if (sel < 62) begin
      push_setup($urandom_range(1) ? ucrh_pkg::RT_EP_IN : 8'($urandom()),
                 ucrh_pkg::REQ_GET_STATUS, 16'($urandom()), 16'($urandom()),
                 16'($urandom()));
    end else if (sel < 72) begin
      push_setup(ucrh_pkg::RT_EP_OUT,
                 $urandom_range(1) ? ucrh_pkg::REQ_SET_FEAT : ucrh_pkg::REQ_CLEAR_FEAT,
                 16'(($urandom_range(7) == 0) ? $urandom() : 0),
                 16'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(7)),
                 16'($urandom()));
    end else if (sel < 84) begin
      push_report(8'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()));
    end else if (sel < 88) begin
      push_op(ucrh_pkg::OP_BUSRST);
    end else if (sel < 92) begin
      push_op($urandom_range(1) ? ucrh_pkg::OP_IN : ucrh_pkg::OP_OUT);
    end else begin
      ev = blank_event(3'($urandom_range(7)));
      ev.rtype = 8'($urandom());
      ev.req = 8'($urandom_range(1) ? $urandom() : $urandom_range(10));
      ev.val = 16'($urandom()); ev.idx = 16'($urandom()); ev.len = 16'($urandom());
      ev.rep_type = 8'($urandom()); ev.dt = 16'($urandom()); ev.xv = 16'($urandom());
      ev.yv = 16'($urandom()); ev.zv = 16'($urandom()); ev.idle_pct = phase_idle;
      pending_words.push_back(ev);
    end
  endtask

  initial begin
    cfg_q = '0; addr_q = '0; addr_en_q = 1'b0; stage_q = 1'b0;
    cursor_q = '0; left_q = '0;
    for (int i = 0; i < 8; i++) halted_q[i] = 1'b0;

    // directed part
    push_op(ucrh_pkg::OP_IN);
    push_op(ucrh_pkg::OP_OUT);
    push_report(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_setup(8'hFF, ucrh_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_setup(ucrh_pkg::RT_DEV_OUT, ucrh_pkg::REQ_SET_CONFIG, 16'h00FF, 16'd0, 16'd0);
    push_report(8'h00, 16'h0000, 16'h1234, 16'hFFFF, 16'h8001);
    push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_CONFIG, 16'd0, 16'd0, 16'd1);
    push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_DESC, 16'h0302, 16'h0409, 16'hFFFF);
    push_op(ucrh_pkg::OP_IN);
    push_op(ucrh_pkg::OP_IN);
    push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_DESC, 16'h0200, 16'd0, 16'hFFFF);
    push_op(ucrh_pkg::OP_IN);
    push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_DESC, 16'h0100, 16'd0, 16'd0);
    push_op(ucrh_pkg::OP_IN);
    push_setup(ucrh_pkg::RT_DEV_IN, ucrh_pkg::REQ_GET_DESC, 16'h0101, 16'd0, 16'd64);
    push_setup(ucrh_pkg::RT_EP_OUT, ucrh_pkg::REQ_SET_FEAT, 16'd0, 16'd4, 16'd0);
    push_setup(ucrh_pkg::RT_EP_IN, ucrh_pkg::REQ_GET_STATUS, 16'd0, 16'hFFFC, 16'd2);
    push_setup(ucrh_pkg::RT_EP_OUT, ucrh_pkg::REQ_SET_FEAT, 16'd0, 16'd0, 16'd0);
    push_setup(ucrh_pkg::RT_EP_OUT, ucrh_pkg::REQ_SET_FEAT, 16'd0, 16'd5, 16'd0);
    push_setup(ucrh_pkg::RT_EP_OUT, ucrh_pkg::REQ_CLEAR_FEAT, 16'd0, 16'h0084, 16'd0);
    push_setup(8'h00, 8'hFF, 16'd0, 16'd0, 16'd0);
    push_op(ucrh_pkg::OP_BUSRST);
    push_report(8'h01, 16'd1, 16'd2, 16'd3, 16'd4);
    push_op(3'd5);
    push_op(3'd7);

    for (int i = 0; i < 96; i++) begin
      case (i / 24)
        0: phase_idle = 0;
        1: phase_idle = 74;
        2: phase_idle = 0;
        default: phase_idle = 22;
      endcase
      push_random_sequence();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d words covering all requests, descriptor reads and reports", accepted);
    $display("checked %0d result words under several idle patterns", results_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
